// ===== sv/pdm_pkg.sv =====
// Shared types and constants for the pixel to DMX channel mapper.
// Used by pdm_ctrl, pdm_dpath and pixel_to_dmx_channel_mapper_top; no dependencies.
`default_nettype none

package pdm_pkg;

    // Field widths fixed by the register map and the item layout.
    localparam int PIX_W     = 12;
    localparam int BYTE_W    = 8;
    localparam int SLOT_W    = 10;
    localparam int COUNT_W   = 4;
    localparam int ROLE_W    = 3;
    localparam int ROLE_SLOTS = 15;
    localparam int ROLES_W   = ROLE_W * ROLE_SLOTS;
    localparam int OUT_ADDR_W = 16;
    // Full slot address: start + gap * (pixel - first) + channel fits in 22 bits.
    localparam int ADDR_W    = 22;
    localparam int CFG_IDX_W = 3;
    localparam int COLORS    = 4;
    localparam int COLOR_SEL_W = 2;

    localparam int MAX_CHANNELS_DEFAULT = 15;
    localparam logic [ADDR_W-1:0] UNIVERSE_SLOTS = ADDR_W'(512);
    localparam logic [BYTE_W-1:0] FULL_BYTE = 8'd255;

    // Channel role codes.
    localparam logic [ROLE_W-1:0] ROLE_ZERO    = 3'd0;
    localparam logic [ROLE_W-1:0] ROLE_RED     = 3'd1;
    localparam logic [ROLE_W-1:0] ROLE_GREEN   = 3'd2;
    localparam logic [ROLE_W-1:0] ROLE_BLUE   = 3'd3;
    localparam logic [ROLE_W-1:0] ROLE_WHITE   = 3'd4;
    localparam logic [ROLE_W-1:0] ROLE_SHUTTER = 3'd5;
    localparam logic [ROLE_W-1:0] ROLE_FULL    = 3'd6;
    localparam logic [ROLE_W-1:0] ROLE_NONE    = 3'd7;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ROLES      = 3'd6;

    typedef struct packed {
        logic                 enable;
        logic [BYTE_W-1:0]    brightness;
        logic [SLOT_W-1:0]    start;
        logic [SLOT_W-1:0]    gap;
        logic [COUNT_W-1:0]   count;
        logic [PIX_W-1:0]     first;
        logic [ROLES_W-1:0]   roles;
    } cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture the pixel and rewind the channel counter
        logic calc;   // compute the fixture base address and the channel mask
        logic emit;   // process the current channel and advance
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic go;     // pixel produces at least one write
        logic last;   // current channel is the last mapped one
    } status_t;

endpackage

`default_nettype wire

// ===== sv/pdm_ctrl.sv =====
// Controller state machine of the pixel to DMX channel mapper.
// Depends on pdm_pkg for the command and status structs.
`default_nettype none

module pdm_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire pdm_pkg::status_t status,
    output pdm_pkg::cmd_t         cmd,
    output logic                  busy
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CALC = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = status.go ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                cmd.emit = 1'b1;
                if (status.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

    // A load is only issued from idle and is always followed by the setup step.
    a_load_then_calc: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> cmd.calc)
        else $error("load not followed by setup");

    // The emit phase never begins unless setup reported work to do.
    a_emit_needs_go: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(cmd.emit) |-> $past(cmd.calc) && $past(status.go))
        else $error("emit phase entered without work");

    // Commands are mutually exclusive.
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("overlapping commands");

endmodule

`default_nettype wire

// ===== sv/pdm_dpath.sv =====
// Datapath of the pixel to DMX channel mapper: base address, channel mask,
// color scaling and the registered result. Depends on pdm_pkg.
`default_nettype none

module pdm_dpath #(
    parameter int MAX_CHANNELS = pdm_pkg::MAX_CHANNELS_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire pdm_pkg::cfg_t                     cfg,
    input  wire pdm_pkg::cmd_t                     cmd,
    output pdm_pkg::status_t                       status,
    input  wire logic [pdm_pkg::PIX_W-1:0]         pixel_index,
    input  wire logic [pdm_pkg::BYTE_W-1:0]        red,
    input  wire logic [pdm_pkg::BYTE_W-1:0]        green,
    input  wire logic [pdm_pkg::BYTE_W-1:0]        blue,
    input  wire logic [pdm_pkg::BYTE_W-1:0]        white,
    output logic                                   strobe,
    output logic [pdm_pkg::OUT_ADDR_W-1:0]         slot_address,
    output logic [pdm_pkg::BYTE_W-1:0]             slot_value,
    output logic                                   out_of_range,
    output logic                                   last_write
);

    localparam int NUM_CH = (MAX_CHANNELS < pdm_pkg::ROLE_SLOTS) ?
                            MAX_CHANNELS : pdm_pkg::ROLE_SLOTS;
    localparam int CH_W   = (NUM_CH > 1) ? $clog2(NUM_CH) : 1;
    localparam int PROD_W = 2 * pdm_pkg::BYTE_W;

    // Divide a product of two bytes by 255; exact for every such product.
    function automatic logic [pdm_pkg::BYTE_W-1:0] div255(input logic [PROD_W-1:0] x);
        logic [PROD_W:0] t;
        t = {1'b0, x} + (PROD_W+1)'(x >> pdm_pkg::BYTE_W) + (PROD_W+1)'(1);
        return t[PROD_W-1:pdm_pkg::BYTE_W];
    endfunction

    logic [pdm_pkg::PIX_W-1:0]  pix_reg;
    logic [pdm_pkg::BYTE_W-1:0] col_reg [pdm_pkg::COLORS];
    logic [pdm_pkg::ADDR_W-1:0] base_reg;
    logic [NUM_CH-1:0]          mask_reg;
    logic                       scale_reg;
    logic [CH_W-1:0]            ch_reg;

    logic                         strobe_reg;
    logic [pdm_pkg::OUT_ADDR_W-1:0] addr_out_reg;
    logic [pdm_pkg::BYTE_W-1:0]   value_out_reg;
    logic                         oor_reg;
    logic                         last_reg;

    logic [pdm_pkg::ROLE_W-1:0] role_arr [NUM_CH];
    logic [NUM_CH-1:0]          mask_comb;
    logic                       shutter_comb;
    logic [pdm_pkg::PIX_W-1:0]  diff;
    logic [pdm_pkg::ADDR_W-1:0] base_next;
    logic [NUM_CH-1:0]          mask_hi;
    logic                       above_empty;
    logic [pdm_pkg::ROLE_W-1:0] role_cur;
    logic [PROD_W-1:0]          product;
    logic [pdm_pkg::BYTE_W-1:0] color_cur;
    logic [pdm_pkg::BYTE_W-1:0] value_next;
    logic [pdm_pkg::ADDR_W-1:0] addr_next;

    // Role decode and mapped-channel mask; each channel is independent.
    always_comb
    begin
        shutter_comb = 1'b0;
        for (int j = 0; j < NUM_CH; j++)
        begin
            role_arr[j]  = cfg.roles[pdm_pkg::ROLE_W*j +: pdm_pkg::ROLE_W];
            mask_comb[j] = (cfg.count > pdm_pkg::COUNT_W'(j)) &&
                           (role_arr[j] != pdm_pkg::ROLE_NONE);
            if ((cfg.count > pdm_pkg::COUNT_W'(j)) &&
                (role_arr[j] == pdm_pkg::ROLE_SHUTTER))
            begin
                shutter_comb = 1'b1;
            end
        end
    end

    assign diff      = pix_reg - cfg.first;
    assign base_next = pdm_pkg::ADDR_W'(cfg.start) +
                       (pdm_pkg::ADDR_W'(cfg.gap) * pdm_pkg::ADDR_W'(diff));

    assign status.go = cfg.enable && (pix_reg >= cfg.first) && (|mask_comb);

    // The current channel is the last one when no mapped channel lies above it.
    assign mask_hi     = mask_reg >> 1;
    assign above_empty = ((mask_hi >> ch_reg) == '0);
    assign status.last = above_empty;

    assign role_cur  = role_arr[ch_reg];
    assign color_cur = col_reg[pdm_pkg::COLOR_SEL_W'(role_cur - pdm_pkg::ROLE_RED)];
    assign product   = PROD_W'(color_cur) * PROD_W'(cfg.brightness);

    always_comb
    begin
        case (role_cur)
            pdm_pkg::ROLE_RED, pdm_pkg::ROLE_GREEN,
            pdm_pkg::ROLE_BLUE, pdm_pkg::ROLE_WHITE:
                value_next = scale_reg ? div255(product) : color_cur;
            pdm_pkg::ROLE_SHUTTER: value_next = cfg.brightness;
            pdm_pkg::ROLE_FULL:    value_next = pdm_pkg::FULL_BYTE;
            default:               value_next = '0;
        endcase
    end

    assign addr_next = base_reg + pdm_pkg::ADDR_W'(ch_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pix_reg    <= pixel_index;
            col_reg[0] <= red;
            col_reg[1] <= green;
            col_reg[2] <= blue;
            col_reg[3] <= white;
        end
        if (cmd.calc)
        begin
            base_reg  <= base_next;
            mask_reg  <= mask_comb;
            scale_reg <= !shutter_comb;
        end
        if (cmd.emit)
        begin
            addr_out_reg  <= addr_next[pdm_pkg::OUT_ADDR_W-1:0];
            value_out_reg <= value_next;
            oor_reg       <= (addr_next > pdm_pkg::UNIVERSE_SLOTS);
            last_reg      <= above_empty;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_reg     <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.emit && mask_reg[ch_reg];
            if (cmd.load)
            begin
                ch_reg <= '0;
            end
            else if (cmd.emit)
            begin
                ch_reg <= ch_reg + CH_W'(1);
            end
        end
    end

    assign strobe       = strobe_reg;
    assign slot_address = addr_out_reg;
    assign slot_value   = value_out_reg;
    assign out_of_range = oor_reg;
    assign last_write   = strobe_reg && last_reg;

    // Every result beat comes from an emit step in the cycle before.
    a_strobe_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |-> $past(cmd.emit))
        else $error("result beat without an emit step");

    // The cycle after a pixel is captured carries no result beat.
    a_no_beat_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> !strobe_reg)
        else $error("result beat right after capture");

    // The final emit step of a pixel always produces a beat.
    a_last_step_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && status.last) |=> strobe_reg && last_reg)
        else $error("last emit step produced no final beat");

endmodule

`default_nettype wire

// ===== sv/pixel_to_dmx_channel_mapper_top.sv =====
// Top level of the pixel to DMX channel mapper: configuration registers and
// the controller and datapath. Depends on pdm_pkg, pdm_ctrl and pdm_dpath.
`default_nettype none

// Usage
// A pixel (pixel_index, red, green, blue, white) is taken at a rising edge
// with start high and busy low. The block then writes the slot beats of the
// fixture that the pixel drives: each beat is on slot_address, slot_value
// and out_of_range for exactly one cycle while strobe is high, in channel
// order, and last_write marks the final beat of the pixel. The receiver
// cannot stall; every beat must be taken in the cycle it is shown.
// After the accept edge a setup step computes the fixture base address with
// a single 10x12 multiply, then one channel is visited per cycle up to the
// highest mapped channel h. Each beat is registered from its channel's emit
// step. Channels mapped to write nothing are still visited. A pixel that is
// disabled, before the first pixel or unmapped gets only the setup step and
// gives no beat. The configuration channel (cfg_valid, cfg_ready,
// cfg_index, cfg_data) is always ready; the user must write it only while
// the block is idle, as the block itself does not enforce this; indexes
// beyond the register list are ignored. Reset clears the controller and
// returns every register to its documented reset value.

module pixel_to_dmx_channel_mapper_top #(
    parameter int MAX_CHANNELS = pdm_pkg::MAX_CHANNELS_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [pdm_pkg::PIX_W-1:0]           pixel_index,
    input  wire logic [pdm_pkg::BYTE_W-1:0]          red,
    input  wire logic [pdm_pkg::BYTE_W-1:0]          green,
    input  wire logic [pdm_pkg::BYTE_W-1:0]          blue,
    input  wire logic [pdm_pkg::BYTE_W-1:0]          white,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [pdm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [pdm_pkg::ROLES_W-1:0]         cfg_data,
    output logic                                     strobe,
    output logic [pdm_pkg::OUT_ADDR_W-1:0]           slot_address,
    output logic [pdm_pkg::BYTE_W-1:0]               slot_value,
    output logic                                     out_of_range,
    output logic                                     last_write
);

    pdm_pkg::cfg_t    cfg_reg;
    pdm_pkg::cmd_t    cmd;
    pdm_pkg::status_t status;

    // The register file takes a write every cycle.
    assign cfg_ready = 1'b1;

    // Each register keeps the low bits of the written data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable     <= 1'b0;
            cfg_reg.brightness <= pdm_pkg::FULL_BYTE;
            cfg_reg.start      <= pdm_pkg::SLOT_W'(1);
            cfg_reg.gap        <= pdm_pkg::SLOT_W'(4);
            cfg_reg.count      <= pdm_pkg::COUNT_W'(4);
            cfg_reg.first      <= '0;
            cfg_reg.roles      <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                pdm_pkg::CFG_ENABLE:     cfg_reg.enable     <= cfg_data[0];
                pdm_pkg::CFG_BRIGHTNESS: cfg_reg.brightness <= cfg_data[pdm_pkg::BYTE_W-1:0];
                pdm_pkg::CFG_START:      cfg_reg.start      <= cfg_data[pdm_pkg::SLOT_W-1:0];
                pdm_pkg::CFG_GAP:        cfg_reg.gap        <= cfg_data[pdm_pkg::SLOT_W-1:0];
                pdm_pkg::CFG_COUNT:      cfg_reg.count      <= cfg_data[pdm_pkg::COUNT_W-1:0];
                pdm_pkg::CFG_FIRST:      cfg_reg.first      <= cfg_data[pdm_pkg::PIX_W-1:0];
                pdm_pkg::CFG_ROLES:      cfg_reg.roles      <= cfg_data;
                default:
                begin
                    // Writes beyond the register list are dropped.
                end
            endcase
        end
    end

    pdm_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    pdm_dpath #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .cmd          (cmd),
        .status       (status),
        .pixel_index  (pixel_index),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .white        (white),
        .strobe       (strobe),
        .slot_address (slot_address),
        .slot_value   (slot_value),
        .out_of_range (out_of_range),
        .last_write   (last_write)
    );

endmodule

`default_nettype wire
